// ----- design/assert_macros.svh -----
// Assertion helpers shared by the decoder modules.
// Each use expands to one labeled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define BMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checked at every edge, reset included.
`define BMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// ----- design/bmprle_pkg.sv -----
`default_nettype none

package bmprle_pkg;

  // Default width of the internal column and line counters.
  localparam int COORD_BITS_DEF = 16;
  // Default depth of the result queue; it must hold at least two items.
  localparam int OFIFO_DEPTH_DEF = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FOUR_BIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_RUN   = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  // Second byte of an escape sequence.
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [6:0] {
    PH_COUNT    = 7'b0000001,
    PH_VALUE    = 7'b0000010,
    PH_ESCAPE   = 7'b0000100,
    PH_ABS_DATA = 7'b0001000,
    PH_ABS_PAD  = 7'b0010000,
    PH_DELTA_X  = 7'b0100000,
    PH_DELTA_Y  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic        four_bit;
    logic [15:0] height;
    logic        bottom_up;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  run_length;
    logic [7:0]  first_index;
    logic [7:0]  second_index;
    logic        last_result;
  } result_t;

  // Results written into the queue in the same cycle: slot0 first, then slot1.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    slot0;
    result_t    slot1;
  } push_t;

endpackage

`default_nettype wire

// ----- design/bmp_rle_index_decoder.sv -----
// Channel   Dir  Handshake              Payload (lowest bit first)
// in_*      in   in_tvalid/in_tready    tdata: data_byte[7:0]; tlast: last_byte
// out_*     out  out_tvalid/out_tready  tdata: row, column, run_length, first_index,
//                                       second_index; tuser: kind; tlast: last_result
// cfg_*     in   cfg_we (no wait)       cfg_index selects, cfg_wdata[15:0] is the value
//
// One compressed byte is accepted per cycle while the result queue has two free
// entries. An accepted byte waits in the input register, is decoded there, and its
// results enter an OFIFO_DEPTH-entry (default four) queue; the first result can
// leave the cycle after that. A byte that yields a run and the premature-end marker
// hands both out one after another. The input stalls while the queue has fewer than
// two free entries, so output back-pressure reaches the input after the queue fills.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to the
// start of an image; configuration takes its reset values.
`default_nettype none

module bmp_rle_index_decoder #(
  parameter int COORD_BITS  = bmprle_pkg::COORD_BITS_DEF,
  parameter int OFIFO_DEPTH = bmprle_pkg::OFIFO_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Compressed input: data_byte[7:0].
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,
  input  wire logic                              in_tlast,
  // Results: row[15:0], column[31:16], run_length[39:32], first_index[47:40],
  // second_index[55:48].
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [55:0]                            out_tdata,
  // Result kind[1:0].
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast,
  // Register writes.
  input  wire logic                              cfg_we,
  input  wire logic [bmprle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bmprle_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bmprle_pkg::cfg_t    cfg_r;
  bmprle_pkg::push_t   push;
  bmprle_pkg::result_t res;
  logic                fifo_room;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.four_bit  <= 1'b0;
      cfg_r.height    <= 16'd1;
      cfg_r.bottom_up <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmprle_pkg::REG_FOUR_BIT:  cfg_r.four_bit  <= cfg_wdata[0];
        bmprle_pkg::REG_HEIGHT:    cfg_r.height    <= cfg_wdata[15:0];
        bmprle_pkg::REG_BOTTOM_UP: cfg_r.bottom_up <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Byte parser: holds the input register, the parse phase, the column and the
  // line, and forms up to two results for each byte.
  bmprle_parse #(
    .COORD_BITS (COORD_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .cfg       (cfg_r),
    .fifo_room (fifo_room),
    .push      (push)
  );

  // Result queue: takes up to two results a cycle and hands out one whenever the output is ready.
  bmprle_ofifo #(
    .DEPTH (OFIFO_DEPTH)
  ) u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (fifo_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {res.second_index, res.first_index, res.run_length,
                      res.column, res.row};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_result;

endmodule

`default_nettype wire

// ----- design/bmprle_parse.sv -----
`default_nettype none

module bmprle_parse #(
  parameter int COORD_BITS = bmprle_pkg::COORD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  wire bmprle_pkg::cfg_t  cfg,
  input  wire logic              fifo_room,
  output bmprle_pkg::push_t      push
);

  `include "assert_macros.svh"

  // Input register.
  logic       stg_v_r, stg_v_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;

  // Parse state.
  bmprle_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]            held_r, held_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] line_r, line_nxt;
  logic [7:0]            abs_left_r, abs_left_nxt;
  logic                  pad_r, pad_nxt;
  logic [7:0]            dx_r, dx_nxt;
  logic                  fin_r, fin_nxt;

  logic                  adv;
  logic                  in_fire;
  logic                  run_en, eob_en, run_out, trunc_en, prim_v;
  logic [7:0]            run_len, run_a, run_b;
  logic [8:0]            byte_inc;
  logic [15:0]           row_diff;
  bmprle_pkg::result_t   run_res, eob_res, trunc_res, prim_res;

  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                    input logic [7:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + (COORD_BITS+1)'(b);
    return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
  endfunction

  // The staged byte moves on only when the queue can take two results.
  assign adv       = stg_v_r && fifo_room;
  assign in_tready = !stg_v_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_fire) begin
      stg_v_nxt = 1'b1;
    end else if (adv) begin
      stg_v_nxt = 1'b0;
    end
  end

  assign byte_inc = {1'b0, stg_byte_r} + 9'd1;

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    col_nxt      = col_r;
    line_nxt     = line_r;
    abs_left_nxt = abs_left_r;
    pad_nxt      = pad_r;
    dx_nxt       = dx_r;
    fin_nxt      = fin_r;
    run_en       = 1'b0;
    eob_en       = 1'b0;
    run_len      = '0;
    run_a        = '0;
    run_b        = '0;

    if (!fin_r) begin
      unique case (phase_r)
        bmprle_pkg::PH_COUNT: begin
          held_nxt  = stg_byte_r;
          phase_nxt = (stg_byte_r != 8'd0) ? bmprle_pkg::PH_VALUE : bmprle_pkg::PH_ESCAPE;
        end
        bmprle_pkg::PH_VALUE: begin
          run_en  = 1'b1;
          run_len = held_r;
          if (cfg.four_bit) begin
            run_a = {4'd0, stg_byte_r[7:4]};
            run_b = {4'd0, stg_byte_r[3:0]};
          end else begin
            run_a = stg_byte_r;
            run_b = stg_byte_r;
          end
          phase_nxt = bmprle_pkg::PH_COUNT;
        end
        bmprle_pkg::PH_ESCAPE: begin
          unique case (stg_byte_r)
            bmprle_pkg::ESC_EOL: begin
              col_nxt   = '0;
              line_nxt  = sat_add(line_r, 8'd1);
              phase_nxt = bmprle_pkg::PH_COUNT;
            end
            bmprle_pkg::ESC_EOB: begin
              eob_en    = 1'b1;
              fin_nxt   = 1'b1;
              phase_nxt = bmprle_pkg::PH_COUNT;
            end
            bmprle_pkg::ESC_DELTA: begin
              phase_nxt = bmprle_pkg::PH_DELTA_X;
            end
            default: begin
              // Absolute run; pad flags an odd number of data bytes.
              abs_left_nxt = stg_byte_r;
              held_nxt     = stg_byte_r;
              pad_nxt      = cfg.four_bit ? byte_inc[1] : stg_byte_r[0];
              phase_nxt    = bmprle_pkg::PH_ABS_DATA;
            end
          endcase
        end
        bmprle_pkg::PH_ABS_DATA: begin
          run_en = 1'b1;
          if (cfg.four_bit) begin
            run_len      = (abs_left_r >= 8'd2) ? 8'd2 : abs_left_r;
            run_a        = {4'd0, stg_byte_r[7:4]};
            run_b        = {4'd0, stg_byte_r[3:0]};
            abs_left_nxt = abs_left_r - run_len;
          end else begin
            run_len      = 8'd1;
            run_a        = stg_byte_r;
            run_b        = stg_byte_r;
            abs_left_nxt = (abs_left_r != 8'd0) ? abs_left_r - 8'd1 : 8'd0;
          end
          if (abs_left_nxt == 8'd0) begin
            phase_nxt = pad_r ? bmprle_pkg::PH_ABS_PAD : bmprle_pkg::PH_COUNT;
          end
        end
        bmprle_pkg::PH_ABS_PAD: begin
          pad_nxt   = 1'b0;
          phase_nxt = bmprle_pkg::PH_COUNT;
        end
        bmprle_pkg::PH_DELTA_X: begin
          dx_nxt    = stg_byte_r;
          phase_nxt = bmprle_pkg::PH_DELTA_Y;
        end
        bmprle_pkg::PH_DELTA_Y: begin
          col_nxt   = sat_add(col_r, dx_r);
          line_nxt  = sat_add(line_r, stg_byte_r);
          phase_nxt = bmprle_pkg::PH_COUNT;
        end
        default: begin
          phase_nxt = bmprle_pkg::PH_COUNT;
        end
      endcase
    end

    // A run advances the column whether or not it lands inside the image.
    if (run_en) begin
      col_nxt = sat_add(col_r, run_len);
    end

    trunc_en = stg_last_r && !fin_nxt;

    // The final byte returns the parser to its start state.
    if (stg_last_r) begin
      phase_nxt    = bmprle_pkg::PH_COUNT;
      held_nxt     = '0;
      col_nxt      = '0;
      line_nxt     = '0;
      abs_left_nxt = '0;
      pad_nxt      = 1'b0;
      dx_nxt       = '0;
      fin_nxt      = 1'b0;
    end
  end

  // Row flip is taken modulo the coordinate range.
  assign row_diff = cfg.height - 16'd1 - 16'(line_r);
  assign run_out  = run_en && (16'(line_r) < cfg.height);
  assign prim_v   = run_out || eob_en;

  always_comb begin
    run_res              = '0;
    run_res.kind         = bmprle_pkg::KIND_RUN;
    run_res.row          = cfg.bottom_up ? 16'(row_diff[COORD_BITS-1:0]) : 16'(line_r);
    run_res.column       = 16'(col_r);
    run_res.run_length   = run_len;
    run_res.first_index  = run_a;
    run_res.second_index = run_b;

    eob_res              = '0;
    eob_res.kind         = bmprle_pkg::KIND_END;

    trunc_res             = '0;
    trunc_res.kind        = bmprle_pkg::KIND_TRUNC;
    trunc_res.last_result = 1'b1;

    prim_res             = run_out ? run_res : eob_res;
    prim_res.last_result = !trunc_en;

    push = '0;
    if (adv) begin
      if (prim_v) begin
        push.slot0 = prim_res;
        push.slot1 = trunc_res;
        push.cnt   = trunc_en ? 2'd2 : 2'd1;
      end else if (trunc_en) begin
        push.slot0 = trunc_res;
        push.cnt   = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_byte_r <= in_byte;
      stg_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r    <= 1'b0;
      phase_r    <= bmprle_pkg::PH_COUNT;
      held_r     <= '0;
      col_r      <= '0;
      line_r     <= '0;
      abs_left_r <= '0;
      pad_r      <= 1'b0;
      dx_r       <= '0;
      fin_r      <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      if (adv) begin
        phase_r    <= phase_nxt;
        held_r     <= held_nxt;
        col_r      <= col_nxt;
        line_r     <= line_nxt;
        abs_left_r <= abs_left_nxt;
        pad_r      <= pad_nxt;
        dx_r       <= dx_nxt;
        fin_r      <= fin_nxt;
      end
    end
  end

  `BMP_ASSERT(a_fin_idle_phase, fin_r |-> (phase_r == bmprle_pkg::PH_COUNT), "finished with parse phase not at count byte")
  `BMP_ASSERT(a_last_clears, (adv && stg_last_r) |=> (phase_r == bmprle_pkg::PH_COUNT && !fin_r && line_r == '0 && col_r == '0), "final byte did not clear parse state")
  `BMP_ASSERT(a_second_is_trunc, (push.cnt == 2'd2) |-> (push.slot1.kind == bmprle_pkg::KIND_TRUNC && stg_last_r), "second result of a byte is not the truncation marker")

endmodule

`default_nettype wire

// ----- design/bmprle_ofifo.sv -----
`default_nettype none

module bmprle_ofifo #(
  parameter int DEPTH = bmprle_pkg::OFIFO_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bmprle_pkg::push_t    push,
  output logic                      room,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output bmprle_pkg::result_t       out_res
);

  `include "assert_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bmprle_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wp1, wp2;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wp1        = ptr_inc(wr_r);
  assign wp2        = ptr_inc(wp1);
  assign room       = count_r <= CW'(DEPTH - 2);
  assign out_tvalid = count_r != '0;
  assign out_res    = mem_r[rd_r];
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    case (push.cnt)
      2'd1:    wr_nxt = wp1;
      2'd2:    wr_nxt = wp2;
      default: wr_nxt = wr_r;
    endcase
    rd_nxt    = pop ? ptr_inc(rd_r) : rd_r;
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.slot0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp1] <= push.slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  `BMP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (count_r == '0), "result queue not empty after reset")
  `BMP_ASSERT(a_push_has_room, (push.cnt != 2'd0) |-> room, "results written into a queue without two free entries")
  `BMP_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "result queue count beyond its depth")

endmodule

`default_nettype wire
